/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Each macro takes a label, the clock, the reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: condition does not hold");
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");
// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/gas_pkg.sv */
package gas_pkg;

   // Fixed field widths
   localparam int COST_W = 13;
   localparam int F_W    = 14;
   localparam int CNT_W  = 13;
   localparam int PEAK_W = 15;

   localparam logic [COST_W-1:0] COST_UNREACHED = 13'd8191;
   localparam logic [COST_W-1:0] COST_MAX       = 13'd8190;
   localparam logic [CNT_W-1:0]  CNT_MAX        = 13'd8191;
   localparam logic [PEAK_W-1:0] PEAK_MAX       = 15'd32767;

   // Commands from the search control to the open list
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } heap_cmd_type;

   // Open list status back to the search control
   typedef struct packed {
      logic busy;
      logic empty;
   } heap_stat_type;

endpackage

/* rtl/grid_astar_search_core.sv */
// A* path search on a grid of up to GRID_SIDE x GRID_SIDE cells, 4-neighbour moves of unit
// cost, Manhattan heuristic; open list is a binary heap of HEAP_DEPTH entries in its own
// memory, cell state (open, closed, path, g score, parent move) in one cell memory and the
// walls in another. One request gives one response. Restart clears the cell state memory.
// A step pops the heap (stale entries cost one pop each) and pushes each relaxed neighbour;
// these sift loops over the heap memory, with one read and one write port, set the step
// time. Reaching the goal adds a parent walk that marks each path cell. After reset the
// block runs a clearing pass over both cell memories before it takes its first request.
`include "assert_macros.svh"

module grid_astar_search_core #(
   parameter int GRID_SIDE  = 64,
   parameter int HEAP_DEPTH = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] cell_x, [11:6] cell_y, [12] wall_bit
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] search_done, [1] path_found, [7:2] expanded_x, [13:8] expanded_y,
   // [14] cell_is_open, [15] cell_is_closed, [16] cell_on_path, [29:17] cell_cost,
   // [42:30] visited_total, [57:43] open_peak, [70:58] path_cells
   output logic [71:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import gas_pkg::*;

   localparam int CW    = $clog2(GRID_SIDE);
   localparam int DW    = (CW + 1 > 7) ? CW + 1 : 7;
   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int IW    = $clog2(CELLS);
   localparam int WCW   = $clog2(CELLS + 1);
   localparam int KEY_W = F_W + 2 * CW;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0, OP_RESTART = 2'd1, OP_STEP = 2'd2, OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_ROWS, REG_COLS, REG_START_X, REG_START_Y, REG_GOAL_X, REG_GOAL_Y, REG_PRESENT
   } reg_idx_type;

   typedef enum logic [4:0] {
      S_SWEEP, S_IDLE, S_QUERY, S_RS_WS, S_RS_WG, S_RS_PUSHW, S_POP, S_POP_WAIT,
      S_POP_CHK, S_NB, S_NB_CHK, S_NB_PUSHW, S_PW, S_PW_RD, S_PW_START, S_PW_SRD, S_FIN
   } state_type;

   typedef struct packed {
      logic              open;
      logic              closed;
      logic              onpath;
      logic [COST_W-1:0] cost;
      logic [2:0]        parent;
   } run_type;

   // Parent move codes: the move that reached the cell
   localparam logic [2:0] DIR_NONE = 3'd0;
   localparam logic [2:0] DIR_PX   = 3'd1;
   localparam logic [2:0] DIR_MX   = 3'd2;
   localparam logic [2:0] DIR_PY   = 3'd3;
   localparam logic [2:0] DIR_MY   = 3'd4;

   localparam run_type RUN_CLEAR = '{1'b0, 1'b0, 1'b0, COST_UNREACHED, DIR_NONE};

   function automatic logic [IW-1:0] cell_idx(input logic [CW-1:0] x, input logic [CW-1:0] y);
      cell_idx = IW'(IW'(y) * IW'(GRID_SIDE) + IW'(x));
   endfunction

   function automatic logic [DW:0] manhattan(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                             input logic [DW-1:0] gx, input logic [DW-1:0] gy);
      logic [DW-1:0] dx;
      logic [DW-1:0] dy;
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      manhattan = (DW + 1)'(dx) + (DW + 1)'(dy);
   endfunction

   // Memories
   logic    wall_mem [CELLS];
   run_type run_mem  [CELLS];

   logic          wall_we, wall_wdata, wall_rdata_ff;
   logic [IW-1:0] wall_waddr, wall_raddr;
   logic          run_we;
   run_type       run_wdata, run_rdata_ff;
   logic [IW-1:0] run_waddr, run_raddr;

   // Configuration
   logic [6:0] rows_ff, cols_ff;
   logic [5:0] sx_ff, sy_ff, gx_ff, gy_ff;
   logic       present_ff;

   // Control
   state_type         state_ff, state_in;
   logic [IW-1:0]     sweep_cnt_ff, sweep_cnt_in;
   logic              sweep_wall_ff, sweep_wall_in;
   logic [CW-1:0]     cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW-1:0]     nb_x_ff, nb_x_in, nb_y_ff, nb_y_in;
   logic [COST_W-1:0] g_ff, g_in;
   logic [1:0]        dir_ff, dir_in;
   logic [WCW-1:0]    walk_cnt_ff, walk_cnt_in;
   logic [5:0]        ex_ff, ex_in, ey_ff, ey_in;
   logic              q_open_ff, q_open_in, q_closed_ff, q_closed_in, q_path_ff, q_path_in;
   logic [COST_W-1:0] q_cost_ff, q_cost_in;
   logic              done_ff, done_in, found_ff, found_in;
   logic [CNT_W-1:0]  visited_ff, visited_in, pathcnt_ff, pathcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [71:0]       rsp_data_ff, rsp_data_in;

   // Open list
   heap_cmd_type      heap_cmd;
   heap_stat_type     heap_stat;
   logic [KEY_W-1:0]  push_key, pop_key;
   logic [PEAK_W-1:0] heap_peak;

   // Derived values
   logic [DW-1:0]  used_cols, used_rows;
   logic [DW-1:0]  rq_xd, rq_yd, sxd, syd, gxd, gyd, cur_xd, cur_yd;
   logic [DW-1:0]  nxd, nyd;
   logic           nb_ok, nb_in;
   logic           start_in, goal_in, accept, rsp_free;
   op_type         rq_op;
   logic [CW-1:0]  key_x, key_y;
   logic [F_W-1:0] f_start, f_nb;

   assign used_cols = (DW'(cols_ff) >= DW'(GRID_SIDE)) ? DW'(GRID_SIDE) : DW'(cols_ff);
   assign used_rows = (DW'(rows_ff) >= DW'(GRID_SIDE)) ? DW'(GRID_SIDE) : DW'(rows_ff);
   assign rq_xd     = DW'(req_tdata[5:0]);
   assign rq_yd     = DW'(req_tdata[11:6]);
   assign rq_op     = op_type'(req_tuser);
   assign sxd       = DW'(sx_ff);
   assign syd       = DW'(sy_ff);
   assign gxd       = DW'(gx_ff);
   assign gyd       = DW'(gy_ff);
   assign cur_xd    = DW'(cur_x_ff);
   assign cur_yd    = DW'(cur_y_ff);
   assign start_in  = (sxd < used_cols) && (syd < used_rows);
   assign goal_in   = (gxd < used_cols) && (gyd < used_rows);
   assign key_x     = pop_key[CW-1:0];
   assign key_y     = pop_key[2*CW-1:CW];
   assign f_start   = F_W'(manhattan(sxd, syd, gxd, gyd));
   assign f_nb      = F_W'(g_ff) + F_W'(manhattan(DW'(nb_x_ff), DW'(nb_y_ff), gxd, gyd));
   assign accept    = req_tvalid && req_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // Neighbour of the current cell in the order +x, -x, +y, -y
   always_comb begin
      nxd   = cur_xd;
      nyd   = cur_yd;
      nb_ok = 1'b1;
      case (dir_ff)
         2'd0: nxd = cur_xd + DW'(1);
         2'd1: begin
            nxd   = cur_xd - DW'(1);
            nb_ok = (cur_x_ff != '0);
         end
         2'd2: nyd = cur_yd + DW'(1);
         default: begin
            nyd   = cur_yd - DW'(1);
            nb_ok = (cur_y_ff != '0);
         end
      endcase
      nb_in = nb_ok && (nxd < used_cols) && (nyd < used_rows);
   end

   // Search control
   always_comb begin
      state_in      = state_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sweep_wall_in = sweep_wall_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      nb_x_in       = nb_x_ff;
      nb_y_in       = nb_y_ff;
      g_in          = g_ff;
      dir_in        = dir_ff;
      walk_cnt_in   = walk_cnt_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      q_open_in     = q_open_ff;
      q_closed_in   = q_closed_ff;
      q_path_in     = q_path_ff;
      q_cost_in     = q_cost_ff;
      done_in       = done_ff;
      found_in      = found_ff;
      visited_in    = visited_ff;
      pathcnt_in    = pathcnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wall_we       = 1'b0;
      wall_waddr    = sweep_cnt_ff;
      wall_wdata    = 1'b0;
      wall_raddr    = '0;
      run_we        = 1'b0;
      run_waddr     = sweep_cnt_ff;
      run_wdata     = RUN_CLEAR;
      run_raddr     = '0;
      heap_cmd      = '0;
      push_key      = {f_nb, nb_y_ff, nb_x_ff};
      unique case (state_ff)
         S_SWEEP: begin
            run_we  = 1'b1;
            wall_we = sweep_wall_ff;
            sweep_cnt_in = sweep_cnt_ff + IW'(1);
            if (sweep_cnt_ff == IW'(CELLS - 1)) begin
               if (sweep_wall_ff) begin
                  sweep_wall_in = 1'b0;
                  state_in      = S_IDLE;
               end else if (!present_ff || !start_in || !goal_in) begin
                  done_in  = 1'b1;
                  state_in = S_FIN;
               end else begin
                  wall_raddr = cell_idx(CW'(sxd), CW'(syd));
                  state_in   = S_RS_WS;
               end
            end
         end
         S_IDLE: begin
            if (accept) begin
               ex_in       = '0;
               ey_in       = '0;
               q_open_in   = 1'b0;
               q_closed_in = 1'b0;
               q_path_in   = 1'b0;
               q_cost_in   = '0;
               unique case (rq_op)
                  OP_LOAD: begin
                     if (rq_xd < DW'(GRID_SIDE) && rq_yd < DW'(GRID_SIDE)) begin
                        wall_we    = 1'b1;
                        wall_waddr = cell_idx(CW'(rq_xd), CW'(rq_yd));
                        wall_wdata = req_tdata[12];
                     end
                     state_in = S_FIN;
                  end
                  OP_RESTART: begin
                     heap_cmd.clear = 1'b1;
                     sweep_cnt_in   = '0;
                     done_in        = 1'b0;
                     found_in       = 1'b0;
                     visited_in     = '0;
                     pathcnt_in     = '0;
                     state_in       = S_SWEEP;
                  end
                  OP_STEP: state_in = done_ff ? S_FIN : S_POP;
                  OP_QUERY: begin
                     if (rq_xd < used_cols && rq_yd < used_rows) begin
                        run_raddr = cell_idx(CW'(rq_xd), CW'(rq_yd));
                        state_in  = S_QUERY;
                     end else begin
                        q_cost_in = COST_UNREACHED;
                        state_in  = S_FIN;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_QUERY: begin
            q_open_in   = run_rdata_ff.open;
            q_closed_in = run_rdata_ff.closed;
            q_path_in   = run_rdata_ff.onpath;
            q_cost_in   = run_rdata_ff.cost;
            state_in    = S_FIN;
         end
         S_RS_WS: begin
            if (wall_rdata_ff) begin
               done_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               wall_raddr = cell_idx(CW'(gxd), CW'(gyd));
               state_in   = S_RS_WG;
            end
         end
         S_RS_WG: begin
            if (wall_rdata_ff) begin
               done_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               // open the start cell with g = 0
               run_we         = 1'b1;
               run_waddr      = cell_idx(CW'(sxd), CW'(syd));
               run_wdata      = '{1'b1, 1'b0, 1'b0, '0, DIR_NONE};
               heap_cmd.push  = 1'b1;
               push_key       = {f_start, CW'(syd), CW'(sxd)};
               state_in       = S_RS_PUSHW;
            end
         end
         S_RS_PUSHW: begin
            if (!heap_stat.busy) begin
               state_in = S_FIN;
            end
         end
         S_POP: begin
            if (heap_stat.empty) begin
               done_in  = 1'b1;
               found_in = 1'b0;
               state_in = S_FIN;
            end else begin
               heap_cmd.pop = 1'b1;
               state_in     = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            if (!heap_stat.busy) begin
               cur_x_in  = key_x;
               cur_y_in  = key_y;
               run_raddr = cell_idx(key_x, key_y);
               state_in  = S_POP_CHK;
            end
         end
         S_POP_CHK: begin
            if (run_rdata_ff.closed) begin
               // drop stale entry
               state_in = S_POP;
            end else begin
               run_we           = 1'b1;
               run_waddr        = cell_idx(cur_x_ff, cur_y_ff);
               run_wdata        = run_rdata_ff;
               run_wdata.open   = 1'b0;
               run_wdata.closed = 1'b1;
               if (visited_ff != CNT_MAX) begin
                  visited_in = visited_ff + CNT_W'(1);
               end
               ex_in = 6'(cur_xd);
               ey_in = 6'(cur_yd);
               if (cur_xd == gxd && cur_yd == gyd) begin
                  done_in     = 1'b1;
                  found_in    = 1'b1;
                  walk_cnt_in = '0;
                  pathcnt_in  = '0;
                  state_in    = S_PW;
               end else begin
                  g_in     = (run_rdata_ff.cost >= COST_MAX) ? COST_MAX :
                             run_rdata_ff.cost + COST_W'(1);
                  dir_in   = '0;
                  state_in = S_NB;
               end
            end
         end
         S_NB: begin
            if (nb_in) begin
               nb_x_in    = CW'(nxd);
               nb_y_in    = CW'(nyd);
               run_raddr  = cell_idx(CW'(nxd), CW'(nyd));
               wall_raddr = cell_idx(CW'(nxd), CW'(nyd));
               state_in   = S_NB_CHK;
            end else if (dir_ff == 2'd3) begin
               state_in = S_FIN;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         S_NB_CHK: begin
            if (!wall_rdata_ff && !run_rdata_ff.closed && g_ff < run_rdata_ff.cost) begin
               // relax: new g, parent move and open flag, then push
               run_we           = 1'b1;
               run_waddr        = cell_idx(nb_x_ff, nb_y_ff);
               run_wdata        = run_rdata_ff;
               run_wdata.open   = 1'b1;
               run_wdata.cost   = g_ff;
               run_wdata.parent = 3'(dir_ff) + 3'd1;
               heap_cmd.push    = 1'b1;
               state_in         = S_NB_PUSHW;
            end else if (dir_ff == 2'd3) begin
               state_in = S_FIN;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = S_NB;
            end
         end
         S_NB_PUSHW: begin
            if (!heap_stat.busy) begin
               if (dir_ff == 2'd3) begin
                  state_in = S_FIN;
               end else begin
                  dir_in   = dir_ff + 2'd1;
                  state_in = S_NB;
               end
            end
         end
         S_PW: begin
            if ((cur_xd == sxd && cur_yd == syd) || walk_cnt_ff == WCW'(CELLS)) begin
               state_in = S_PW_START;
            end else begin
               run_raddr = cell_idx(cur_x_ff, cur_y_ff);
               state_in  = S_PW_RD;
            end
         end
         S_PW_RD: begin
            run_we           = 1'b1;
            run_waddr        = cell_idx(cur_x_ff, cur_y_ff);
            run_wdata        = run_rdata_ff;
            run_wdata.onpath = 1'b1;
            if (pathcnt_ff != CNT_MAX) begin
               pathcnt_in = pathcnt_ff + CNT_W'(1);
            end
            walk_cnt_in = walk_cnt_ff + WCW'(1);
            state_in    = S_PW;
            // step back against the move that reached this cell
            case (run_rdata_ff.parent)
               DIR_PX:  cur_x_in = cur_x_ff - CW'(1);
               DIR_MX:  cur_x_in = cur_x_ff + CW'(1);
               DIR_PY:  cur_y_in = cur_y_ff - CW'(1);
               DIR_MY:  cur_y_in = cur_y_ff + CW'(1);
               default: state_in = S_PW_START;
            endcase
         end
         S_PW_START: begin
            if (sxd < DW'(GRID_SIDE) && syd < DW'(GRID_SIDE)) begin
               run_raddr = cell_idx(CW'(sxd), CW'(syd));
               state_in  = S_PW_SRD;
            end else begin
               if (pathcnt_ff != CNT_MAX) begin
                  pathcnt_in = pathcnt_ff + CNT_W'(1);
               end
               state_in = S_FIN;
            end
         end
         S_PW_SRD: begin
            run_we           = 1'b1;
            run_waddr        = cell_idx(CW'(sxd), CW'(syd));
            run_wdata        = run_rdata_ff;
            run_wdata.onpath = 1'b1;
            if (pathcnt_ff != CNT_MAX) begin
               pathcnt_in = pathcnt_ff + CNT_W'(1);
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, pathcnt_ff, heap_peak, visited_ff, q_cost_ff,
                               q_path_ff, q_closed_ff, q_open_ff, ey_ff, ex_ff,
                               found_ff, done_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Cell memories
   always_ff @(posedge clock) begin
      if (wall_we) begin
         wall_mem[wall_waddr] <= wall_wdata;
      end
      wall_rdata_ff <= wall_mem[wall_raddr];
      if (run_we) begin
         run_mem[run_waddr] <= run_wdata;
      end
      run_rdata_ff <= run_mem[run_raddr];
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_cnt_ff  <= '0;
         sweep_wall_ff <= 1'b1;
         done_ff       <= 1'b1;
         found_ff      <= 1'b0;
         visited_ff    <= '0;
         pathcnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         sweep_wall_ff <= sweep_wall_in;
         done_ff       <= done_in;
         found_ff      <= found_in;
         visited_ff    <= visited_in;
         pathcnt_ff    <= pathcnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      nb_x_ff     <= nb_x_in;
      nb_y_ff     <= nb_y_in;
      g_ff        <= g_in;
      dir_ff      <= dir_in;
      walk_cnt_ff <= walk_cnt_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      q_open_ff   <= q_open_in;
      q_closed_ff <= q_closed_in;
      q_path_ff   <= q_path_in;
      q_cost_ff   <= q_cost_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= 7'd64;
         cols_ff    <= 7'd64;
         sx_ff      <= '0;
         sy_ff      <= '0;
         gx_ff      <= '0;
         gy_ff      <= '0;
         present_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx_type'(csr_paddr[4:2]))
            REG_ROWS:    rows_ff    <= csr_pwdata[6:0];
            REG_COLS:    cols_ff    <= csr_pwdata[6:0];
            REG_START_X: sx_ff      <= csr_pwdata[5:0];
            REG_START_Y: sy_ff      <= csr_pwdata[5:0];
            REG_GOAL_X:  gx_ff      <= csr_pwdata[5:0];
            REG_GOAL_Y:  gy_ff      <= csr_pwdata[5:0];
            REG_PRESENT: present_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (reg_idx_type'(csr_paddr[4:2]))
         REG_ROWS:    csr_prdata = 32'(rows_ff);
         REG_COLS:    csr_prdata = 32'(cols_ff);
         REG_START_X: csr_prdata = 32'(sx_ff);
         REG_START_Y: csr_prdata = 32'(sy_ff);
         REG_GOAL_X:  csr_prdata = 32'(gx_ff);
         REG_GOAL_Y:  csr_prdata = 32'(gy_ff);
         REG_PRESENT: csr_prdata = 32'(present_ff);
         default:     csr_prdata = '0;
      endcase
   end

   gas_heap #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .KEY_W      (KEY_W)
   ) u_heap (
      .clock    (clock),
      .reset    (reset),
      .cmd      (heap_cmd),
      .push_key (push_key),
      .stat     (heap_stat),
      .pop_key  (pop_key),
      .peak     (heap_peak)
   );

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLIES(a_found_done, clock, reset, found_ff, done_ff)
   `ASSERT_IMPLIES(a_accept_heap_idle, clock, reset, req_tvalid && req_tready, !heap_stat.busy)
   `ASSERT_NEXT(a_fin_holds, clock, reset, state_ff == S_FIN && rsp_valid_ff && !rsp_tready, state_ff == S_FIN)

endmodule

/* rtl/gas_heap.sv */
`include "assert_macros.svh"

module gas_heap #(
   parameter int HEAP_DEPTH = 16384,
   parameter int KEY_W      = 26
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gas_pkg::heap_cmd_type      cmd,
   input  logic [KEY_W-1:0]           push_key,
   output gas_pkg::heap_stat_type     stat,
   output logic [KEY_W-1:0]           pop_key,
   output logic [gas_pkg::PEAK_W-1:0] peak
);
   import gas_pkg::*;

   localparam int AW   = $clog2(HEAP_DEPTH);
   localparam int CNTW = $clog2(HEAP_DEPTH + 1);
   localparam int XW   = AW + 2;
   localparam int PCW  = (CNTW > PEAK_W) ? CNTW : PEAK_W;

   typedef enum logic [3:0] {
      H_IDLE, H_PU_CMP, H_PU_FIN, H_PO_TOP, H_PO_LAST,
      H_SD_C, H_SD_R0, H_SD_R1, H_SD_CMP
   } hstate_type;

   logic [KEY_W-1:0] heap_mem [HEAP_DEPTH];

   hstate_type        state_ff, state_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [PEAK_W-1:0] peak_ff, peak_in;
   logic [AW-1:0]     i_ff, i_in;
   logic [AW-1:0]     p_ff, p_in;
   logic [AW-1:0]     c_ff, c_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  last_ff, last_in;
   logic [KEY_W-1:0]  cv_ff, cv_in;
   logic [KEY_W-1:0]  top_ff, top_in;
   logic [KEY_W-1:0]  rdata_ff;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [KEY_W-1:0]  mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [XW-1:0]     child_w;
   logic [XW-1:0]     sib_w;
   logic [CNTW-1:0]   count_inc;

   assign child_w   = XW'({i_ff, 1'b1});
   assign sib_w     = XW'(c_ff) + XW'(1);
   assign count_inc = count_ff + CNTW'(1);

   // Sift engine: one memory read and one write per cycle
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      peak_in   = peak_ff;
      i_in      = i_ff;
      p_in      = p_ff;
      c_in      = c_ff;
      key_in    = key_ff;
      last_in   = last_ff;
      cv_in     = cv_ff;
      top_in    = top_ff;
      mem_we    = 1'b0;
      mem_waddr = i_ff;
      mem_wdata = key_ff;
      mem_raddr = '0;
      unique case (state_ff)
         H_IDLE: begin
            if (cmd.clear) begin
               count_in = '0;
               peak_in  = '0;
            end else if (cmd.push) begin
               if (count_ff < CNTW'(HEAP_DEPTH)) begin
                  count_in = count_inc;
                  if (PCW'(count_inc) > PCW'(peak_ff)) begin
                     peak_in = (PCW'(count_inc) < PCW'(PEAK_MAX)) ?
                               PEAK_W'(count_inc) : PEAK_MAX;
                  end
                  if (count_ff == '0) begin
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = push_key;
                  end else begin
                     i_in      = AW'(count_ff);
                     p_in      = AW'((AW'(count_ff) - AW'(1)) >> 1);
                     mem_raddr = p_in;
                     key_in    = push_key;
                     state_in  = H_PU_CMP;
                  end
               end
            end else if (cmd.pop) begin
               count_in  = count_ff - CNTW'(1);
               mem_raddr = '0;
               state_in  = H_PO_TOP;
            end
         end
         H_PU_CMP: begin
            mem_we = 1'b1;
            if (rdata_ff <= key_ff) begin
               mem_wdata = key_ff;
               state_in  = H_IDLE;
            end else begin
               mem_wdata = rdata_ff;
               i_in      = p_ff;
               if (p_ff == '0) begin
                  state_in = H_PU_FIN;
               end else begin
                  p_in      = AW'((p_ff - AW'(1)) >> 1);
                  mem_raddr = p_in;
               end
            end
         end
         H_PU_FIN: begin
            mem_we    = 1'b1;
            mem_wdata = key_ff;
            state_in  = H_IDLE;
         end
         H_PO_TOP: begin
            top_in = rdata_ff;
            if (count_ff == '0) begin
               state_in = H_IDLE;
            end else begin
               mem_raddr = AW'(count_ff);
               state_in  = H_PO_LAST;
            end
         end
         H_PO_LAST: begin
            last_in  = rdata_ff;
            i_in     = '0;
            state_in = H_SD_C;
         end
         H_SD_C: begin
            if (child_w >= XW'(count_ff)) begin
               mem_we    = 1'b1;
               mem_wdata = last_ff;
               state_in  = H_IDLE;
            end else begin
               c_in      = AW'(child_w);
               mem_raddr = AW'(child_w);
               state_in  = H_SD_R0;
            end
         end
         H_SD_R0: begin
            cv_in = rdata_ff;
            if (sib_w < XW'(count_ff)) begin
               mem_raddr = AW'(sib_w);
               state_in  = H_SD_R1;
            end else begin
               state_in = H_SD_CMP;
            end
         end
         H_SD_R1: begin
            if (rdata_ff < cv_ff) begin
               cv_in = rdata_ff;
               c_in  = AW'(sib_w);
            end
            state_in = H_SD_CMP;
         end
         H_SD_CMP: begin
            mem_we = 1'b1;
            if (last_ff <= cv_ff) begin
               mem_wdata = last_ff;
               state_in  = H_IDLE;
            end else begin
               mem_wdata = cv_ff;
               i_in      = c_ff;
               state_in  = H_SD_C;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   // Heap storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= heap_mem[mem_raddr];
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         count_ff <= '0;
         peak_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         peak_ff  <= peak_in;
      end
      i_ff    <= i_in;
      p_ff    <= p_in;
      c_ff    <= c_in;
      key_ff  <= key_in;
      last_ff <= last_in;
      cv_ff   <= cv_in;
      top_ff  <= top_in;
   end

   assign stat.busy  = (state_ff != H_IDLE);
   assign stat.empty = (count_ff == '0);
   assign pop_key    = top_ff;
   assign peak       = peak_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNTW'(HEAP_DEPTH))
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, state_ff == H_IDLE && cmd.pop && !cmd.clear && !cmd.push, count_ff != '0)
   `ASSERT_IMPLIES(a_sift_child, clock, reset, state_ff == H_SD_R0 || state_ff == H_SD_CMP, XW'(c_ff) < XW'(count_ff))

endmodule

/* tb/sv/grid_astar_search_core_checker.sv */
`timescale 1ns / 1ps

package gas_tb_pkg;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_RESTART = 2'd1,
      OP_STEP    = 2'd2,
      OP_QUERY   = 2'd3
   } gas_op_type;

   typedef enum logic [2:0] {
      REG_ROWS    = 3'd0,
      REG_COLS    = 3'd1,
      REG_START_X = 3'd2,
      REG_START_Y = 3'd3,
      REG_GOAL_X  = 3'd4,
      REG_GOAL_Y  = 3'd5,
      REG_PRESENT = 3'd6
   } gas_reg_type;

endpackage

module grid_astar_search_core_checker
   import gas_pkg::*;
   import gas_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] cell_x, [11:6] cell_y, [12] wall_bit
   input  logic [1:0]  req_tuser,   // [1:0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] search_done, [1] path_found, [7:2] expanded_x, [13:8] expanded_y,
   // [14] cell_is_open, [15] cell_is_closed, [16] cell_on_path, [29:17] cell_cost,
   // [42:30] visited_total, [57:43] open_peak, [70:58] path_cells
   input  logic [71:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          pending
);

   localparam int SIDE   = 64;
   localparam int CELLS  = SIDE * SIDE;
   localparam int DEPTH  = 16384;
   localparam int KEY_SH = 20;

   typedef struct {
      logic                done;
      logic                found;
      logic [5:0]          ex;
      logic [5:0]          ey;
      logic                is_open;
      logic                is_closed;
      logic                on_path;
      logic [COST_W-1:0]   cost;
      logic [CNT_W-1:0]    visited;
      logic [PEAK_W-1:0]   peak;
      logic [CNT_W-1:0]    path_len;
   } search_status_type;

   // register copies
   logic [6:0] rows_reg, cols_reg;
   logic [5:0] sx, sy, gx, gy;
   logic       present;

   // cell and open list state
   bit                wall[CELLS];
   bit                open_f[CELLS];
   bit                closed_f[CELLS];
   bit                path_f[CELLS];
   logic [COST_W-1:0] g_cost[CELLS];
   logic [2:0]        came_from[CELLS];
   logic [63:0]       heap[DEPTH];
   int                heap_n;
   bit                done_f, found_f;
   int                visited_n, peak_n, path_n;

   search_status_type status_q[$];

   const int step_dx[4] = '{1, -1, 0, 0};
   const int step_dy[4] = '{0, 0, 1, -1};

   function automatic int rows_used();
      return (rows_reg < SIDE) ? rows_reg : SIDE;
   endfunction

   function automatic int cols_used();
      return (cols_reg < SIDE) ? cols_reg : SIDE;
   endfunction

   function automatic bit on_grid(int x, int y);
      return x >= 0 && y >= 0 && x < cols_used() && y < rows_used();
   endfunction

   function automatic void heap_insert(logic [63:0] key);
      int i, p;
      if (heap_n >= DEPTH) return;
      i = heap_n;
      heap_n++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (heap[p] <= key) break;
         heap[i] = heap[p];
         i = p;
      end
      heap[i] = key;
      if (heap_n > peak_n) peak_n = (heap_n < 32767) ? heap_n : 32767;
   endfunction

   function automatic logic [63:0] heap_take();
      logic [63:0] top, last;
      int i, c;
      top = heap[0];
      i = 0;
      heap_n--;
      if (heap_n == 0) return top;
      last = heap[heap_n];
      forever begin
         c = 2 * i + 1;
         if (c >= heap_n) break;
         if (c + 1 < heap_n && heap[c + 1] < heap[c]) c++;
         if (last <= heap[c]) break;
         heap[i] = heap[c];
         i = c;
      end
      heap[i] = last;
      return top;
   endfunction

   function automatic void open_node(int idx, int g);
      int x, y, h;
      x = idx % SIDE;
      y = idx / SIDE;
      h = ((x > gx) ? x - gx : gx - x) + ((y > gy) ? y - gy : gy - y);
      open_f[idx] = 1;
      heap_insert((64'(g + h) << KEY_SH) | 64'(idx));
   endfunction

   // walk parent moves back from the goal
   function automatic void trace_route();
      int x, y, idx, d;
      x = gx;
      y = gy;
      foreach (path_f[i]) path_f[i] = 0;
      path_n = 0;
      for (int n = 0; n < CELLS; n++) begin
         if (x == sx && y == sy) break;
         if (x < 0 || y < 0 || x >= SIDE || y >= SIDE) break;
         idx = y * SIDE + x;
         path_f[idx] = 1;
         if (path_n < 8191) path_n++;
         d = came_from[idx];
         if (d == 0 || d > 4) break;
         x -= step_dx[d - 1];
         y -= step_dy[d - 1];
      end
      path_f[sy * SIDE + sx] = 1;
      if (path_n < 8191) path_n++;
   endfunction

   function automatic void restart_search();
      foreach (open_f[i]) begin
         open_f[i]    = 0;
         closed_f[i]  = 0;
         path_f[i]    = 0;
         came_from[i] = 0;
         g_cost[i]    = COST_UNREACHED;
      end
      heap_n    = 0;
      done_f    = 0;
      found_f   = 0;
      visited_n = 0;
      peak_n    = 0;
      path_n    = 0;
      if (!present || !on_grid(sx, sy) || !on_grid(gx, gy) ||
          wall[sy * SIDE + sx] || wall[gy * SIDE + gx]) begin
         done_f = 1;
         return;
      end
      g_cost[sy * SIDE + sx] = 0;
      open_node(sy * SIDE + sx, 0);
   endfunction

   // close the best open node and relax its neighbors
   function automatic void expand_node(ref search_status_type r);
      int idx, x, y, g, nx, ny, n;
      bit got;
      got = 0;
      idx = 0;
      if (done_f) return;
      while (heap_n > 0) begin
         idx = int'(heap_take() & 64'hFFFFF);
         if (idx < CELLS && !closed_f[idx]) begin
            got = 1;
            break;
         end
      end
      if (!got) begin
         done_f  = 1;
         found_f = 0;
         return;
      end
      open_f[idx]   = 0;
      closed_f[idx] = 1;
      if (visited_n < 8191) visited_n++;
      x = idx % SIDE;
      y = idx / SIDE;
      r.ex = 6'(x);
      r.ey = 6'(y);
      if (x == gx && y == gy) begin
         done_f  = 1;
         found_f = 1;
         trace_route();
         return;
      end
      g = g_cost[idx] + 1;
      if (g > COST_MAX) g = COST_MAX;
      for (int d = 0; d < 4; d++) begin
         nx = x + step_dx[d];
         ny = y + step_dy[d];
         if (!on_grid(nx, ny)) continue;
         n = ny * SIDE + nx;
         if (wall[n] || closed_f[n]) continue;
         if (g < g_cost[n]) begin
            g_cost[n]    = COST_W'(g);
            came_from[n] = 3'(d + 1);
            open_node(n, g);
         end
      end
   endfunction

   function automatic search_status_type predict_request(gas_op_type op, int cx, int cy,
                                                         bit wb);
      search_status_type r;
      int i;
      r = '{default: '0};
      case (op)
         OP_LOAD:    wall[cy * SIDE + cx] = wb;
         OP_RESTART: restart_search();
         OP_STEP:    expand_node(r);
         default: begin
            r.cost = COST_UNREACHED;
            if (on_grid(cx, cy)) begin
               i = cy * SIDE + cx;
               r.is_open   = open_f[i];
               r.is_closed = closed_f[i];
               r.on_path   = path_f[i];
               r.cost      = g_cost[i];
            end
         end
      endcase
      r.done     = done_f;
      r.found    = found_f;
      r.visited  = CNT_W'(visited_n);
      r.peak     = PEAK_W'(peak_n);
      r.path_len = CNT_W'(path_n);
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t: response %s = %0d, predicted %0d", $time, field, got, want);
      errors++;
   endtask

   task automatic check_field(string field, longint got, longint want);
      if (got != want) report_mismatch(field, got, want);
   endtask

   initial begin
      errors = 0;
      pending = 0;
      rows_reg = 64;
      cols_reg = 64;
      {sx, sy, gx, gy, present} = '0;
      foreach (wall[i]) begin
         wall[i] = 0; open_f[i] = 0; closed_f[i] = 0; path_f[i] = 0;
         came_from[i] = 0; g_cost[i] = COST_UNREACHED;
      end
      heap_n = 0; done_f = 1; found_f = 0;
      visited_n = 0; peak_n = 0; path_n = 0;
   end

   always @(posedge clock) begin
      search_status_type want;
      if (!reset) begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (gas_reg_type'(csr_paddr[4:2]))
               REG_ROWS:    rows_reg = csr_pwdata[6:0];
               REG_COLS:    cols_reg = csr_pwdata[6:0];
               REG_START_X: sx = csr_pwdata[5:0];
               REG_START_Y: sy = csr_pwdata[5:0];
               REG_GOAL_X:  gx = csr_pwdata[5:0];
               REG_GOAL_Y:  gy = csr_pwdata[5:0];
               REG_PRESENT: present = csr_pwdata[0];
               default: ;
            endcase
         end
         // predict each accepted request
         if (req_tvalid && req_tready)
            status_q.push_back(predict_request(gas_op_type'(req_tuser), req_tdata[5:0],
                                               req_tdata[11:6], req_tdata[12]));
         // compare each accepted response
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               report_mismatch("without request", 1, 0);
            end else begin
               want = status_q.pop_front();
               check_field("search_done", rsp_tdata[0], want.done);
               check_field("path_found", rsp_tdata[1], want.found);
               check_field("expanded_x", rsp_tdata[7:2], want.ex);
               check_field("expanded_y", rsp_tdata[13:8], want.ey);
               check_field("cell_is_open", rsp_tdata[14], want.is_open);
               check_field("cell_is_closed", rsp_tdata[15], want.is_closed);
               check_field("cell_on_path", rsp_tdata[16], want.on_path);
               check_field("cell_cost", rsp_tdata[29:17], want.cost);
               check_field("visited_total", rsp_tdata[42:30], want.visited);
               check_field("open_peak", rsp_tdata[57:43], want.peak);
               check_field("path_cells", rsp_tdata[70:58], want.path_len);
            end
         end
         pending = status_q.size();
      end
   end

endmodule

/* tb/sv/grid_astar_search_core_test.sv */
`timescale 1ns / 1ps

module grid_astar_search_core_test;
   import gas_tb_pkg::*;

   localparam int IDLE_LIMIT = 300000;

   logic        clock;
   logic        reset;
   logic        req_tvalid, req_tready;
   logic [15:0] req_tdata;   // [5:0] cell_x, [11:6] cell_y, [12] wall_bit
   logic [1:0]  req_tuser;   // [1:0] op
   logic        rsp_tvalid, rsp_tready;
   // [0] search_done, [1] path_found, [7:2] expanded_x, [13:8] expanded_y,
   // [14] cell_is_open, [15] cell_is_closed, [16] cell_on_path, [29:17] cell_cost,
   // [42:30] visited_total, [57:43] open_peak, [70:58] path_cells
   logic [71:0] rsp_tdata;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   int          errors, pending;
   int          idle_cycles;
   int          sent;
   bit          calm;
   int          rows, cols;

   grid_astar_search_core dut (.*);

   grid_astar_search_core_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // response side: random stalls, none while calm
   initial begin
      int stall;
      rsp_tready = 0;
      @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[grid_astar_search_core] ERROR");
         $finish;
      end
   end

   task automatic send_request(gas_op_type op, int x, int y, bit wb);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, wb, 6'(y), 6'(x)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // hold requests until every response is back, then let the block settle
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(gas_reg_type r, int value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   task automatic set_search(int nr, int nc, int ax, int ay, int bx, int by, bit both);
      drain();
      write_reg(REG_ROWS, nr);
      write_reg(REG_COLS, nc);
      write_reg(REG_START_X, ax);
      write_reg(REG_START_Y, ay);
      write_reg(REG_GOAL_X, bx);
      write_reg(REG_GOAL_Y, by);
      write_reg(REG_PRESENT, both);
   endtask

   function automatic int pick_in(int n);
      return (n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, (n < 64 ? n : 64) - 1)
                                                  : $urandom_range(0, 63);
   endfunction

   initial begin
      int steps, loads, pick;
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tuser   = OP_LOAD;
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      calm        = 0;
      sent        = 0;
      repeat (8) @(posedge clock);
      reset <= 0;

      // reset settings: no endpoints
      send_request(OP_QUERY, 0, 0, 0);
      send_request(OP_STEP, 0, 0, 0);
      send_request(OP_RESTART, 0, 0, 0);
      send_request(OP_LOAD, 63, 63, 1);
      send_request(OP_QUERY, 63, 63, 0);
      // one-cell grid: start equals goal
      set_search(1, 1, 0, 0, 0, 0, 1);
      send_request(OP_RESTART, 0, 0, 0);
      send_request(OP_STEP, 0, 0, 0);
      send_request(OP_QUERY, 0, 0, 0);
      send_request(OP_QUERY, 5, 5, 0);
      send_request(OP_STEP, 0, 0, 0);
      // full grid with the goal on a wall
      set_search(64, 64, 0, 0, 63, 63, 1);
      send_request(OP_RESTART, 0, 0, 0);
      send_request(OP_LOAD, 63, 63, 0);
      send_request(OP_RESTART, 0, 0, 0);
      send_request(OP_STEP, 0, 0, 0);
      send_request(OP_STEP, 0, 0, 0);
      send_request(OP_QUERY, 1, 0, 0);
      // goal outside the rows in use, oversized and empty register values
      set_search(4, 127, 2, 1, 3, 10, 1);
      send_request(OP_RESTART, 0, 0, 0);
      send_request(OP_QUERY, 2, 1, 0);
      set_search(0, 5, 0, 0, 1, 0, 1);
      send_request(OP_RESTART, 0, 0, 0);
      send_request(OP_QUERY, 0, 0, 0);

      // random searches on mostly small grids
      while (sent < 1200) begin
         pick = $urandom_range(0, 29);
         rows = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(65, 127) :
                (pick < 5) ? 64 : $urandom_range(1, 12);
         pick = $urandom_range(0, 29);
         cols = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(65, 127) :
                (pick < 5) ? 64 : $urandom_range(1, 12);
         set_search(rows, cols, pick_in(cols), pick_in(rows), pick_in(cols), pick_in(rows),
                    $urandom_range(0, 9) != 0);
         calm = ($urandom_range(0, 3) == 0);
         // wall loads, about one in four of them a wall
         loads = (rows < 64 && cols < 64) ? (rows * cols) / 3 + 1 : 30;
         if (loads > 40) loads = 40;
         repeat (loads)
            send_request(OP_LOAD, pick_in(cols), pick_in(rows), $urandom_range(0, 3) == 0);
         send_request(OP_RESTART, 0, 0, 0);
         steps = (rows < 64 && cols < 64) ? rows * cols + 4 : 60;
         if (steps > 150) steps = 150;
         repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
               send_request(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 1));
            else if (pick < 93)
               send_request(OP_QUERY, pick_in(cols), pick_in(rows), $urandom_range(0, 1));
            else if (pick < 98)
               send_request(OP_LOAD, pick_in(cols), pick_in(rows), $urandom_range(0, 1));
            else
               send_request(OP_RESTART, $urandom_range(0, 63), $urandom_range(0, 63), 0);
         end
         // read back six cells, mostly within the grid in use
         repeat (6)
            send_request(OP_QUERY, pick_in(cols), pick_in(rows), 0);
      end

      // wrap up
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("[grid_astar_search_core] OK");
      else
         $display("[grid_astar_search_core] ERROR");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/gas_pkg.sv
rtl/gas_heap.sv
rtl/grid_astar_search_core.sv
tb/sv/grid_astar_search_core_checker.sv
tb/sv/grid_astar_search_core_test.sv
